FILE: hdl/spidec_pkg.sv
package spidec_pkg;

    localparam int SAMPLE_INDEX_BITS_DEF = 48;
    localparam int COUNT_BITS_DEF        = 32;
    localparam int BYTE_BITS             = 8;
    localparam int RES_DEPTH             = 4;

    typedef enum logic [1:0] {
        KIND_BIT  = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    // Push flags for the results that one decoded item hands to the result queue.
    typedef struct packed {
        logic push0;
        logic push1;
    } t_push;

endpackage

FILE: hdl/spidec_decode.sv
module spidec_decode
    import spidec_pkg::*;
#(
    parameter int SAMPLE_INDEX_BITS = SAMPLE_INDEX_BITS_DEF,
    parameter int COUNT_BITS        = COUNT_BITS_DEF,
    parameter int RES_W             = 2 + 2 * SAMPLE_INDEX_BITS + 2 * BYTE_BITS + COUNT_BITS + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_clk_level,
    input  logic                         i_mosi_level,
    input  logic                         i_miso_level,
    input  logic                         i_select_n,
    input  logic [SAMPLE_INDEX_BITS-1:0] i_sample_number,
    input  logic                         i_room,
    output t_push                        o_push,
    output logic [RES_W-1:0]             o_res0,
    output logic [RES_W-1:0]             o_res1
);

    localparam int BIT_CNT_W = $clog2(BYTE_BITS);

    // Input register.
    logic                         r_in_valid;
    logic                         r_clk_lv;
    logic                         r_mosi_lv;
    logic                         r_miso_lv;
    logic                         r_sel_n;
    logic [SAMPLE_INDEX_BITS-1:0] r_now;

    // Decoder state.
    logic                         r_seen_first, n_seen_first;
    logic                         r_prev_clock, n_prev_clock;
    logic                         r_prev_select, n_prev_select;
    logic [BYTE_BITS-1:0]         r_mosi_shift, n_mosi_shift;
    logic [BYTE_BITS-1:0]         r_miso_shift, n_miso_shift;
    logic [BIT_CNT_W-1:0]         r_bits_held, n_bits_held;
    logic [SAMPLE_INDEX_BITS-1:0] r_byte_begin, n_byte_begin;
    logic [SAMPLE_INDEX_BITS-1:0] r_xfer_begin, n_xfer_begin;
    logic                         r_xfer_open, n_xfer_open;
    logic [COUNT_BITS-1:0]        r_xfer_count, n_xfer_count;

    logic                         fire;
    logic                         sel_fall;
    logic                         sel_rise;
    logic                         clk_rise;
    logic                         byte_done;
    logic                         end_res;
    logic [SAMPLE_INDEX_BITS-1:0] bit_span_lo;
    logic [SAMPLE_INDEX_BITS-1:0] byte_span_lo;
    logic [BYTE_BITS-1:0]         mosi_acc;
    logic [BYTE_BITS-1:0]         miso_acc;
    logic [BYTE_BITS-1:0]         mosi_bit;
    logic [BYTE_BITS-1:0]         miso_bit;
    logic                         open_eff;
    logic [COUNT_BITS-1:0]        count_eff;

    assign fire    = r_in_valid & i_room;
    assign o_ready = ~r_in_valid | i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_clk_lv  <= i_clk_level;
            r_mosi_lv <= i_mosi_level;
            r_miso_lv <= i_miso_level;
            r_sel_n   <= i_select_n;
            r_now     <= i_sample_number;
        end
    end

    // Edge detection against the previous sample.
    assign sel_fall     = ~r_sel_n & r_prev_select;
    assign sel_rise     = r_sel_n & ~r_prev_select;
    assign clk_rise     = r_clk_lv & ~r_prev_clock & ~r_sel_n;
    assign byte_done    = r_bits_held == BIT_CNT_W'(BYTE_BITS - 1);
    assign bit_span_lo  = r_now - SAMPLE_INDEX_BITS'(1);
    assign byte_span_lo = (r_bits_held == '0) ? bit_span_lo : r_byte_begin;
    assign mosi_acc     = {r_mosi_shift[BYTE_BITS-2:0], r_mosi_lv};
    assign miso_acc     = {r_miso_shift[BYTE_BITS-2:0], r_miso_lv};
    assign mosi_bit     = {{(BYTE_BITS-1){1'b0}}, r_mosi_lv};
    assign miso_bit     = {{(BYTE_BITS-1){1'b0}}, r_miso_lv};
    // A falling select opens the transfer before the bit on the same sample counts.
    assign open_eff     = sel_fall | r_xfer_open;
    assign count_eff    = sel_fall ? '0 : r_xfer_count;
    assign end_res      = sel_rise & r_xfer_open & (r_xfer_count != '0);

    always_comb begin
        n_seen_first  = r_seen_first;
        n_prev_clock  = r_prev_clock;
        n_prev_select = r_prev_select;
        n_mosi_shift  = r_mosi_shift;
        n_miso_shift  = r_miso_shift;
        n_bits_held   = r_bits_held;
        n_byte_begin  = r_byte_begin;
        n_xfer_begin  = r_xfer_begin;
        n_xfer_open   = r_xfer_open;
        n_xfer_count  = r_xfer_count;
        if (fire) begin
            n_prev_clock  = r_clk_lv;
            n_prev_select = r_sel_n;
            if (!r_seen_first) begin
                n_seen_first = 1'b1;
                if (!r_sel_n && !r_xfer_open) begin
                    n_xfer_begin = r_now;
                    n_xfer_count = '0;
                    n_xfer_open  = 1'b1;
                end
            end else begin
                if (sel_fall) begin
                    n_xfer_begin = r_now;
                    n_xfer_count = '0;
                    n_xfer_open  = 1'b1;
                end
                if (sel_rise) begin
                    n_xfer_open  = 1'b0;
                    n_xfer_count = '0;
                    n_bits_held  = '0;
                    n_mosi_shift = '0;
                    n_miso_shift = '0;
                end
                if (clk_rise) begin
                    n_byte_begin = byte_span_lo;
                    if (byte_done) begin
                        n_mosi_shift = '0;
                        n_miso_shift = '0;
                        n_bits_held  = '0;
                        if (open_eff && count_eff != {COUNT_BITS{1'b1}}) begin
                            n_xfer_count = count_eff + COUNT_BITS'(1);
                        end
                    end else begin
                        n_mosi_shift = mosi_acc;
                        n_miso_shift = miso_acc;
                        n_bits_held  = r_bits_held + BIT_CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_first  <= 1'b0;
            r_prev_clock  <= 1'b0;
            r_prev_select <= 1'b0;
            r_mosi_shift  <= '0;
            r_miso_shift  <= '0;
            r_bits_held   <= '0;
            r_byte_begin  <= '0;
            r_xfer_begin  <= '0;
            r_xfer_open   <= 1'b0;
            r_xfer_count  <= '0;
        end else begin
            r_seen_first  <= n_seen_first;
            r_prev_clock  <= n_prev_clock;
            r_prev_select <= n_prev_select;
            r_mosi_shift  <= n_mosi_shift;
            r_miso_shift  <= n_miso_shift;
            r_bits_held   <= n_bits_held;
            r_byte_begin  <= n_byte_begin;
            r_xfer_begin  <= n_xfer_begin;
            r_xfer_open   <= n_xfer_open;
            r_xfer_count  <= n_xfer_count;
        end
    end

    // Rising select and a counted clock edge never share a sample, so at most
    // two results come out: the end of a transfer, or a bit and maybe its byte.
    always_comb begin
        o_push.push0 = fire & r_seen_first & (end_res | clk_rise);
        o_push.push1 = fire & r_seen_first & clk_rise & byte_done;
        if (end_res) begin
            o_res0 = {KIND_END, r_xfer_begin, r_now, {BYTE_BITS{1'b0}},
                      {BYTE_BITS{1'b0}}, r_xfer_count, 1'b1};
        end else begin
            o_res0 = {KIND_BIT, bit_span_lo, r_now, mosi_bit, miso_bit,
                      {COUNT_BITS{1'b0}}, ~byte_done};
        end
        o_res1 = {KIND_BYTE, byte_span_lo, r_now, mosi_acc, miso_acc,
                  {COUNT_BITS{1'b0}}, 1'b1};
    end

    a_byte_needs_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.push1 |-> o_push.push0)
        else $error("byte result without its bit result");

    a_first_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen_first |-> !o_push.push0)
        else $error("result from the baseline sample");

endmodule

FILE: hdl/spidec_res_queue.sv
module spidec_res_queue
    import spidec_pkg::*;
#(
    parameter int RES_W = 2 + 2 * SAMPLE_INDEX_BITS_DEF + 2 * BYTE_BITS + COUNT_BITS_DEF + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_push            i_push,
    input  logic [RES_W-1:0] i_res0,
    input  logic [RES_W-1:0] i_res1,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [RES_W-1:0] o_res
);

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    logic [RES_W-1:0] r_mem [RES_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr1;

    // Room for two results is checked before the item is decoded.
    assign o_room  = r_count <= CNT_W'(RES_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_res   = r_mem[r_rd_ptr];
    assign pop     = o_valid & i_ready;
    assign wr_ptr1 = r_wr_ptr + PTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push.push0) + PTR_W'(i_push.push1);
        n_rd_ptr = r_rd_ptr + PTR_W'(pop);
        n_count  = r_count + CNT_W'(i_push.push0) + CNT_W'(i_push.push1) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push.push1) begin
            r_mem[wr_ptr1] <= i_res1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RES_DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push0 |-> o_room)
        else $error("result pushed without room");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !i_push.push0 |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("pop did not drain the queue");

endmodule

FILE: hdl/spi_mode0_sample_decoder_top.sv
// SPI mode 0 sample decoder. Each input item is one logic-analyzer sample
// (clock, MOSI, MISO, active-low select, sample number); each output item is
// a decoded bit, an assembled byte (MSB first), or the end of a transfer with
// its span and saturating byte count, and the last flag marks the final result
// of a sample. Samples are registered, decoded in one pass into a four-deep
// result queue and taken one per clock while it has room for two results. A
// sample completing a byte yields two results; the output drains one per clock
// while i_ready is high, so such samples run at the output rate. The first
// sample after reset sets baseline levels, opening a transfer if select is low.
module spi_mode0_sample_decoder_top
    import spidec_pkg::*;
#(
    parameter int SAMPLE_INDEX_BITS = SAMPLE_INDEX_BITS_DEF,
    parameter int COUNT_BITS        = COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_clk_level,
    input  logic                         i_mosi_level,
    input  logic                         i_miso_level,
    input  logic                         i_select_n,
    input  logic [SAMPLE_INDEX_BITS-1:0] i_sample_number,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_kind,
    output logic [SAMPLE_INDEX_BITS-1:0] o_span_start,
    output logic [SAMPLE_INDEX_BITS-1:0] o_span_end,
    output logic [BYTE_BITS-1:0]         o_mosi_value,
    output logic [BYTE_BITS-1:0]         o_miso_value,
    output logic [COUNT_BITS-1:0]        o_transfer_bytes,
    output logic                         o_last
);

    localparam int RES_W = 2 + 2 * SAMPLE_INDEX_BITS + 2 * BYTE_BITS + COUNT_BITS + 1;

    t_push            push;
    logic             room;
    logic [RES_W-1:0] res0;
    logic [RES_W-1:0] res1;
    logic [RES_W-1:0] res_out;

    spidec_decode #(
        .SAMPLE_INDEX_BITS (SAMPLE_INDEX_BITS),
        .COUNT_BITS        (COUNT_BITS),
        .RES_W             (RES_W)
    ) u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_clk_level     (i_clk_level),
        .i_mosi_level    (i_mosi_level),
        .i_miso_level    (i_miso_level),
        .i_select_n      (i_select_n),
        .i_sample_number (i_sample_number),
        .i_room          (room),
        .o_push          (push),
        .o_res0          (res0),
        .o_res1          (res1)
    );

    spidec_res_queue #(
        .RES_W (RES_W)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (res_out)
    );

    assign {o_kind, o_span_start, o_span_end, o_mosi_value, o_miso_value,
            o_transfer_bytes, o_last} = res_out;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import spidec_pkg::*;

    localparam int SIW        = SAMPLE_INDEX_BITS_DEF;
    localparam int CW         = COUNT_BITS_DEF;
    localparam int STALL_MAX  = 2000;
    localparam int DRAIN_WAIT = 20;
    localparam int PHASE_ITEMS = 550;

    typedef struct {
        logic           clk;
        logic           mosi;
        logic           miso;
        logic           sel;
        logic [SIW-1:0] num;
        int             phase;
    } sample_t;

    typedef struct {
        t_kind          kind;
        logic [SIW-1:0] span_lo;
        logic [SIW-1:0] span_hi;
        logic [7:0]     mosi;
        logic [7:0]     miso;
        logic [CW-1:0]  nbytes;
        logic           last;
    } decoded_t;

    logic            i_clk;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            o_ready;
    logic            i_clk_level = 1'b0;
    logic            i_mosi_level = 1'b0;
    logic            i_miso_level = 1'b0;
    logic            i_select_n = 1'b1;
    logic [SIW-1:0]  i_sample_number = '0;
    logic            o_valid;
    logic            i_ready = 1'b0;
    logic [1:0]      o_kind;
    logic [SIW-1:0]  o_span_start;
    logic [SIW-1:0]  o_span_end;
    logic [7:0]      o_mosi_value;
    logic [7:0]      o_miso_value;
    logic [CW-1:0]   o_transfer_bytes;
    logic            o_last;

    sample_t  sample_q[$];
    decoded_t pending_results[$];

    // Idle percentages per phase for the sample sender and the result receiver.
    int send_idle_pct[3] = '{11, 74, 0};
    int recv_idle_pct[3] = '{74, 11, 0};
    int run_phase = 0;
    int gen_phase = 0;
    logic [SIW-1:0] stamp = '0;

    int fail_count = 0;
    int stall_cycles = 0;

    // Decoder state mirrored by the predictor.
    logic           seen_first = 1'b0;
    logic           prev_sck = 1'b0;
    logic           prev_sel = 1'b0;
    logic [7:0]     mosi_acc = '0;
    logic [7:0]     miso_acc = '0;
    logic [2:0]     nbits = '0;
    logic [SIW-1:0] byte_lo = '0;
    logic [SIW-1:0] xfer_start = '0;
    logic           xfer_open = 1'b0;
    logic [CW-1:0]  xfer_bytes = '0;

    spi_mode0_sample_decoder_top #(
        .SAMPLE_INDEX_BITS(SIW),
        .COUNT_BITS(CW)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_clk_level(i_clk_level),
        .i_mosi_level(i_mosi_level),
        .i_miso_level(i_miso_level),
        .i_select_n(i_select_n),
        .i_sample_number(i_sample_number),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_kind(o_kind),
        .o_span_start(o_span_start),
        .o_span_end(o_span_end),
        .o_mosi_value(o_mosi_value),
        .o_miso_value(o_miso_value),
        .o_transfer_bytes(o_transfer_bytes),
        .o_last(o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic rand_level();
        return 1'($urandom_range(1));
    endfunction

    function automatic decoded_t make_result(t_kind kind, logic [SIW-1:0] lo,
                                             logic [SIW-1:0] hi, logic [7:0] mo,
                                             logic [7:0] mi, logic [CW-1:0] n);
        decoded_t r;
        r.kind    = kind;
        r.span_lo = lo;
        r.span_hi = hi;
        r.mosi    = mo;
        r.miso    = mi;
        r.nbytes  = n;
        r.last    = 1'b0;
        return r;
    endfunction

    task automatic decode_sample(input sample_t s);
        decoded_t       found[$];
        logic [SIW-1:0] bit_lo;
        if (!seen_first) begin
            // The first sample only sets the baseline, but a low select opens a transfer.
            prev_sck   = s.clk;
            prev_sel   = s.sel;
            seen_first = 1'b1;
            if (!s.sel && !xfer_open) begin
                xfer_start = s.num;
                xfer_bytes = '0;
                xfer_open  = 1'b1;
            end
            return;
        end
        if (!s.sel && prev_sel) begin
            xfer_start = s.num;
            xfer_bytes = '0;
            xfer_open  = 1'b1;
        end
        if (s.sel && !prev_sel) begin
            if (xfer_open && xfer_bytes != '0) begin
                found.push_back(make_result(KIND_END, xfer_start, s.num, 8'h00, 8'h00,
                                            xfer_bytes));
            end
            xfer_open  = 1'b0;
            xfer_bytes = '0;
            nbits      = '0;
            mosi_acc   = '0;
            miso_acc   = '0;
        end
        if (s.clk && !prev_sck && !s.sel) begin
            bit_lo = s.num - 1'b1;
            if (nbits == 3'd0) begin
                byte_lo = bit_lo;
            end
            found.push_back(make_result(KIND_BIT, bit_lo, s.num, {7'b0, s.mosi},
                                        {7'b0, s.miso}, '0));
            mosi_acc = {mosi_acc[6:0], s.mosi};
            miso_acc = {miso_acc[6:0], s.miso};
            if (nbits == 3'(BYTE_BITS - 1)) begin
                found.push_back(make_result(KIND_BYTE, byte_lo, s.num, mosi_acc,
                                            miso_acc, '0));
                if (xfer_open && xfer_bytes != '1) begin
                    xfer_bytes = xfer_bytes + 1'b1;
                end
                mosi_acc = '0;
                miso_acc = '0;
                nbits    = '0;
            end else begin
                nbits = nbits + 1'b1;
            end
        end
        prev_sck = s.clk;
        prev_sel = s.sel;
        if (found.size() > 0) begin
            found[found.size() - 1].last = 1'b1;
        end
        foreach (found[k]) begin
            pending_results.push_back(found[k]);
        end
    endtask

    task automatic push_sample(input logic c, input logic mo, input logic mi,
                               input logic sel);
        sample_t s;
        s.clk   = c;
        s.mosi  = mo;
        s.miso  = mi;
        s.sel   = sel;
        s.num   = stamp;
        s.phase = gen_phase;
        sample_q.push_back(s);
        stamp = stamp + SIW'(1 + $urandom_range(0, 2));
    endtask

    // One SPI bit: clock low with arbitrary data, then the rising edge that samples it.
    task automatic push_bit(input logic mo, input logic mi);
        push_sample(1'b0, rand_level(), rand_level(), 1'b0);
        push_sample(1'b1, mo, mi, 1'b0);
        if ($urandom_range(4) == 0) begin
            push_sample(1'b1, rand_level(), rand_level(), 1'b0);
        end
    endtask

    task automatic push_transfer(input bit broken);
        int nbytes;
        int extra;
        int k;
        if ($urandom_range(99) < 4) begin
            stamp = SIW'({$urandom, $urandom});
        end else if ($urandom_range(99) < 2) begin
            stamp = '1 - SIW'($urandom_range(0, 40));
        end
        repeat ($urandom_range(0, 2)) begin
            push_sample(1'b0, rand_level(), rand_level(), 1'b1);
        end
        push_sample(1'b0, rand_level(), rand_level(), 1'b0);
        nbytes = ($urandom_range(9) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
        extra  = (broken || $urandom_range(99) < 25) ? $urandom_range(1, 7) : 0;
        for (k = 0; k < nbytes * 8 + extra; k++) begin
            // Broken transfers get spurious clock toggles between bits.
            if (broken && $urandom_range(3) == 0) begin
                push_sample(rand_level(), rand_level(), rand_level(), 1'b0);
            end
            push_bit(rand_level(), rand_level());
        end
        push_sample(rand_level(), rand_level(), rand_level(), 1'b1);
    endtask

    // Sample sender.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                decode_sample(sample_q[0]);
                run_phase <= sample_q[0].phase;
                sample_q.pop_front();
            end
            if (!i_valid || o_ready) begin
                if (sample_q.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct[sample_q[0].phase]) begin
                    i_clk_level     <= sample_q[0].clk;
                    i_mosi_level    <= sample_q[0].mosi;
                    i_miso_level    <= sample_q[0].miso;
                    i_select_n      <= sample_q[0].sel;
                    i_sample_number <= sample_q[0].num;
                    i_valid         <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct[run_phase]);
    end

    always @(posedge i_clk) begin : result_check
        decoded_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected result: kind %0d span %h..%h",
                             o_kind, o_span_start, o_span_end,
                             " mosi %h miso %h bytes %0d last %b",
                             o_mosi_value, o_miso_value, o_transfer_bytes, o_last);
                end
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_kind !== want.kind || o_span_start !== want.span_lo ||
                    o_span_end !== want.span_hi || o_mosi_value !== want.mosi ||
                    o_miso_value !== want.miso || o_transfer_bytes !== want.nbytes ||
                    o_last !== want.last) begin
                    if (fail_count < 10) begin
                        $display("mismatch: expected kind %0d span %h..%h",
                                 want.kind, want.span_lo, want.span_hi,
                                 " mosi %h miso %h bytes %0d last %b",
                                 want.mosi, want.miso, want.nbytes, want.last);
                        $display("          actual   kind %0d span %h..%h",
                                 o_kind, o_span_start, o_span_end,
                                 " mosi %h miso %h bytes %0d last %b",
                                 o_mosi_value, o_miso_value, o_transfer_bytes, o_last);
                    end
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_MAX) begin
            $display("watchdog expired with %0d samples and %0d results outstanding",
                     sample_q.size(), pending_results.size());
            $display("[spi_mode0_sample_decoder_top] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int k;
        int p;
        int r;
        int target;

        // Directed part. Select is already low on the very first sample.
        gen_phase = 0;
        stamp = '0;
        push_sample(1'b0, 1'b0, 1'b0, 1'b0);
        // A rising clock at sample zero wraps the bit start to all ones.
        stamp = '0;
        push_sample(1'b1, 1'b1, 1'b0, 1'b0);
        for (k = 1; k < 8; k++) begin
            push_sample(1'b0, 1'b0, 1'b1, 1'b0);
            if (k == 7) begin
                stamp = '1;
            end
            push_sample(1'b1, k[0], ~k[0], 1'b0);
        end
        push_sample(1'b0, 1'b0, 1'b0, 1'b1);
        // A transfer with no bytes closes silently.
        push_sample(1'b0, 1'b1, 1'b1, 1'b0);
        push_sample(1'b0, 1'b0, 1'b0, 1'b1);
        push_sample(1'b1, 1'b1, 1'b1, 1'b1);
        // A partial byte is dropped when select rises.
        push_sample(1'b0, 1'b0, 1'b0, 1'b0);
        push_bit(1'b1, 1'b1);
        push_bit(1'b0, 1'b1);
        push_sample(1'b0, 1'b0, 1'b0, 1'b1);

        for (p = 0; p < 3; p++) begin
            gen_phase = p;
            target = sample_q.size() + PHASE_ITEMS;
            while (sample_q.size() < target) begin
                r = $urandom_range(99);
                if (r < 75) begin
                    push_transfer(1'b0);
                end else if (r < 88) begin
                    push_transfer(1'b1);
                end else begin
                    repeat ($urandom_range(1, 8)) begin
                        push_sample(rand_level(), rand_level(), rand_level(),
                                    rand_level());
                    end
                end
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sample_q.size() > 0 || pending_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("[spi_mode0_sample_decoder_top] OK");
        end else begin
            $display("[spi_mode0_sample_decoder_top] ERROR");
        end
        $finish;
    end

endmodule
